/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for concurrent assertions clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/goef_pkg.sv */
// ----------------------------------------------------------------------------
// goef_pkg
// Types, widths and helpers shared by the gyro offset / EMA filter block.
// ----------------------------------------------------------------------------
package goef_pkg;

  localparam int RAW_W             = 16;
  localparam int FRACTION_BITS     = 8;
  localparam int VAL_W             = RAW_W + FRACTION_BITS + 1;
  localparam int ALPHA_W           = 17;
  localparam int ALPHA_FRAC        = 16;
  localparam int TOL_W             = 15;
  localparam int CFG_DATA_W        = ALPHA_W;
  localparam int CFG_IDX_W         = 1;
  localparam int CALIB_SAMPLES_DEF = 25;
  localparam int AXES              = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1 << ALPHA_FRAC);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(16384);
  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(100);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 1'b1;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // per-item lane controls, already qualified by the advance strobe
  typedef struct packed {
    logic load_raw;
    logic run_filter;
  } goef_mode_t;

  // raw counts to fixed point
  function automatic val_t scale_raw(raw_t r);
    return {r[RAW_W-1], r, {FRACTION_BITS{1'b0}}};
  endfunction

endpackage

/* hw/rtl/goef_if.sv */
// ----------------------------------------------------------------------------
// goef_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface goef_in_if;
  import goef_pkg::*;
  logic valid;
  logic ready;
  logic action;
  raw_t raw_x;
  raw_t raw_y;
  raw_t raw_z;
  modport source (output valid, action, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, action, raw_x, raw_y, raw_z, output ready);
endinterface

interface goef_out_if;
  import goef_pkg::*;
  logic valid;
  logic ready;
  val_t rate_x;
  val_t rate_y;
  val_t rate_z;
  logic calibrating;
  modport source (output valid, rate_x, rate_y, rate_z, calibrating, input ready);
  modport sink   (input valid, rate_x, rate_y, rate_z, calibrating, output ready);
endinterface

/* hw/rtl/goef_calib.sv */
// ----------------------------------------------------------------------------
// goef_calib
// Calibration sequencer: sums, sample count, offset averaging, x check.
// ----------------------------------------------------------------------------
module goef_calib #(
  parameter int CALIB_SAMPLES = goef_pkg::CALIB_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      action,
  input  goef_pkg::raw_t            raw [goef_pkg::AXES],
  input  logic [goef_pkg::TOL_W-1:0] tol,
  output goef_pkg::val_t            offset [goef_pkg::AXES],
  output logic                      active,
  output goef_pkg::goef_mode_t      mode
);
  import goef_pkg::*;

  localparam int SUM_W   = RAW_W + $clog2(CALIB_SAMPLES);
  localparam int CNT_W   = $clog2(CALIB_SAMPLES + 1);
  localparam int T_W     = SUM_W + FRACTION_BITS + 2;
  localparam int DIV     = 2 * CALIB_SAMPLES;
  localparam int DIV_L   = $clog2(DIV);
  localparam int SH      = T_W + DIV_L;
  localparam int RECIP_W = T_W + 1;
  localparam int PROD_W  = T_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << SH) + DIV - 1) / DIV;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic signed [SUM_W-1:0] sum_r   [AXES];
  logic signed [SUM_W-1:0] sum_nxt [AXES];
  val_t                    off_r   [AXES];
  val_t                    avg     [AXES];
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    active_r;
  logic                    checking_r;
  logic                    out_of_tol;
  logic signed [VAL_W:0]   dev;
  logic signed [VAL_W:0]   tolv;

  // sum*2^FB/N rounded half away from zero: reciprocal multiply, exact for T_W-bit input
  always_comb begin
    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic [T_W-1:0]    t;
    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  q;
    for (int i = 0; i < AXES; i++) begin
      sum_nxt[i] = sum_r[i] + SUM_W'(raw[i]);
      neg  = sum_nxt[i][SUM_W-1];
      mag  = neg ? (~sum_nxt[i] + 1'b1) : sum_nxt[i];
      t    = T_W'({mag, {FRACTION_BITS{1'b0}}, 1'b0}) + T_W'(CALIB_SAMPLES);
      prod = PROD_W'(t) * PROD_W'(RECIP_C);
      q    = prod[SH +: VAL_W];
      avg[i] = neg ? val_t'(~q + 1'b1) : val_t'(q);
    end
  end

  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    dev  = (VAL_W+1)'(scale_raw(raw[0])) - (VAL_W+1)'(off_r[0]);
    tolv = (VAL_W+1)'({tol, {FRACTION_BITS{1'b0}}});
    out_of_tol = (dev > tolv) || (dev < -tolv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        sum_r[i] <= '0;
        off_r[i] <= '0;
      end
      cnt_r      <= '0;
      active_r   <= 1'b0;
      checking_r <= 1'b0;
    end else if (advance) begin
      if (action) begin
        for (int i = 0; i < AXES; i++) begin
          sum_r[i] <= '0;
          off_r[i] <= '0;
        end
        cnt_r      <= '0;
        checking_r <= 1'b0;
        active_r   <= 1'b1;
      end else if (active_r) begin
        if (checking_r) begin
          cnt_r      <= '0;
          checking_r <= 1'b0;
          if (out_of_tol) begin
            // restart the pass
            for (int i = 0; i < AXES; i++) begin
              sum_r[i] <= '0;
              off_r[i] <= '0;
            end
          end else begin
            active_r <= 1'b0;
          end
        end else begin
          for (int i = 0; i < AXES; i++) sum_r[i] <= sum_nxt[i];
          cnt_r <= cnt_inc;
          if (cnt_inc >= CNT_W'(CALIB_SAMPLES)) begin
            for (int i = 0; i < AXES; i++) off_r[i] <= avg[i];
            checking_r <= 1'b1;
          end
        end
      end
    end
  end

  assign offset          = off_r;
  assign active          = active_r;
  assign mode.load_raw   = advance && !action && active_r;
  assign mode.run_filter = advance && !action && !active_r;

endmodule

/* hw/rtl/goef_lane.sv */
// ----------------------------------------------------------------------------
// goef_lane
// One axis: filtered value register and its EMA update.
// ----------------------------------------------------------------------------
module goef_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  goef_pkg::goef_mode_t        mode,
  input  logic [goef_pkg::ALPHA_W-1:0] alpha,
  input  goef_pkg::raw_t              raw,
  input  goef_pkg::val_t              offset,
  output goef_pkg::val_t              filt
);
  import goef_pkg::*;

  localparam int ERR_W  = VAL_W + 2;
  localparam int PROD_W = ALPHA_W + 1 + ERR_W;
  localparam int STEP_W = PROD_W - ALPHA_FRAC;
  localparam int ACC_W  = STEP_W + 1;
  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  val_t                     filt_r;
  val_t                     scaled;
  val_t                     filt_nxt;
  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [ACC_W-1:0]  acc;

  // alpha*(x-off) + (1-alpha)*f  ==  f + alpha*((x-off) - f)
  always_comb begin
    scaled = scale_raw(raw);
    err    = ERR_W'(scaled) - ERR_W'(offset) - ERR_W'(filt_r);
    prod   = $signed({1'b0, alpha}) * err;
    rnd    = prod + PROD_W'(1 << (ALPHA_FRAC - 1));
    acc    = ACC_W'(filt_r) + ACC_W'($signed(rnd[PROD_W-1:ALPHA_FRAC]));
    if (acc > ACC_W'(VAL_MAX)) begin
      filt_nxt = VAL_MAX;
    end else if (acc < ACC_W'(VAL_MIN)) begin
      filt_nxt = VAL_MIN;
    end else begin
      filt_nxt = acc[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (mode.load_raw) begin
      filt_r <= scaled;
    end else if (mode.run_filter) begin
      filt_r <= filt_nxt;
    end
  end

  assign filt = filt_r;

endmodule

/* hw/rtl/gyro_offset_ema_filter_unit.sv */
// ----------------------------------------------------------------------------
// gyro_offset_ema_filter_unit
// Three-axis rate conditioner: offset calibration pass and EMA filter.
//
//   port     dir   handshake     word
//   in_ch    in    valid/ready   action, raw_x, raw_y, raw_z
//   out_ch   out   valid/ready   rate_x, rate_y, rate_z, calibrating
//   cfg_*    in    cfg_we        cfg_idx, cfg_wdata (no read-back)
//
// One word per cycle sustained while out_ch is not stalled; the result word
// is valid after the input register and then the state registers take it.
// The filter, offset average and check all run between the input register
// and the state registers, which also hold the result word.
// Synchronous active-low reset clears all but input data; no clearing pass.
// A stalled output holds; the input register keeps accepting while free.
// ----------------------------------------------------------------------------
module gyro_offset_ema_filter_unit #(
  parameter int CALIB_SAMPLES = goef_pkg::CALIB_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  goef_in_if.sink                         in_ch,
  goef_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [goef_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [goef_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import goef_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  logic [TOL_W-1:0]   tol_r;
  logic               in_vld_r;
  logic               in_action_r;
  raw_t               in_raw_r [AXES];
  logic               out_vld_r;
  logic               advance;
  logic               active;
  goef_mode_t         mode;
  val_t               offset [AXES];
  val_t               filt   [AXES];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      tol_r   <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ALPHA: alpha_r <= (cfg_wdata[ALPHA_W-1:0] > ALPHA_ONE) ?
                              ALPHA_ONE : cfg_wdata[ALPHA_W-1:0];
        REG_TOL:   tol_r   <= cfg_wdata[TOL_W-1:0];
        default:   ;
      endcase
    end
  end

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_action_r <= in_ch.action;
      in_raw_r[0] <= in_ch.raw_x;
      in_raw_r[1] <= in_ch.raw_y;
      in_raw_r[2] <= in_ch.raw_z;
    end
  end

  goef_calib #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_calib (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .action  (in_action_r),
    .raw     (in_raw_r),
    .tol     (tol_r),
    .offset  (offset),
    .active  (active),
    .mode    (mode)
  );

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    goef_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .mode   (mode),
      .alpha  (alpha_r),
      .raw    (in_raw_r[g]),
      .offset (offset[g]),
      .filt   (filt[g])
    );
  end

  // state registers only move on advance, so they double as the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.rate_x      = filt[0];
  assign out_ch.rate_y      = filt[1];
  assign out_ch.rate_z      = filt[2];
  assign out_ch.calibrating = active;

endmodule

/* hw/rtl/goef_checker.sv */
// ----------------------------------------------------------------------------
// goef_checker
// Port-level checks on throughput, latency and output hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module goef_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input goef_pkg::val_t rate_x,
  input goef_pkg::val_t rate_y,
  input goef_pkg::val_t rate_z,
  input logic           calibrating
);
  import goef_pkg::*;

  // a free output never blocks the input
  `AM_ASSERT_IMPL(a_no_block, out_ready, in_ready)

  // every accepted word is followed by a valid result word
  `AM_ASSERT_IMPL(a_latency, in_valid && in_ready, ##2 out_valid)

  // stalled result word holds
  `AM_ASSERT_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(rate_x) && $stable(rate_y) && $stable(rate_z) &&
    $stable(calibrating))

endmodule

bind gyro_offset_ema_filter_unit goef_checker u_goef_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .rate_x      (out_ch.rate_x),
  .rate_y      (out_ch.rate_y),
  .rate_z      (out_ch.rate_z),
  .calibrating (out_ch.calibrating)
);
